/* hdl/tli_pkg.sv */
// Package for the table linear interpolator: widths, status codes, state
// types, the table write request and the difference magnitude helper.
// No dependencies.
`default_nettype none

package tli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int VALUE_W     = 32;
    localparam int DIFF_W      = VALUE_W + 1;
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int QUO_W       = VALUE_W + 1;
    localparam int RES_W       = VALUE_W + 2;
    localparam int RATIO_W     = VALUE_W + 4;
    localparam int RATIO_LIMIT = 10;
    localparam int MIN_COUNT   = 2;
    localparam int STATUS_W    = 3;

    // Radix-2 division, two quotient bits per cycle.
    localparam int DIV_STEPS = 2;
    localparam int DIV_ITERS = VALUE_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = CNT_W'(MIN_COUNT);

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXTRAP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DOMAIN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WRITE  = 3'd4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_LAST,
        S_LOWER,
        S_UPPER,
        S_CHECK,
        S_DECIDE,
        S_DIV_GO,
        S_DIV_WAIT
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_ROUND
    } t_div_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] y;
    } t_mem_wr;

    // Magnitude of a difference of two values; it never exceeds 2^VALUE_W - 1.
    function automatic logic [VALUE_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] t;
        t = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
        return t[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/tli_table_mem.sv */
// Breakpoint store: two synchronous single-port-read memories for x and y.
// Depends on tli_pkg for widths and the write request type.
`default_nettype none

module tli_table_mem (
    input  wire logic                     i_clk,
    input  wire tli_pkg::t_mem_wr         i_wr,
    input  wire logic [tli_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic      [tli_pkg::VALUE_W-1:0] o_rd_x,
    output logic      [tli_pkg::VALUE_W-1:0] o_rd_y
);
    import tli_pkg::*;

    logic [VALUE_W-1:0] mem_x [TABLE_DEPTH];
    logic [VALUE_W-1:0] mem_y [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_x[i_wr.addr] <= i_wr.x;
            mem_y[i_wr.addr] <= i_wr.y;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_x <= mem_x[i_rd_addr];
        o_rd_y <= mem_y[i_rd_addr];
    end

endmodule

`default_nettype wire

/* hdl/tli_divider.sv */
// Serial rounding divider: 2*VALUE_W-bit dividend by VALUE_W-bit divisor,
// quotient rounded half away from zero and capped at 2^VALUE_W. Uses tli_pkg.
`default_nettype none

module tli_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tli_pkg::PROD_W-1:0]  i_dividend,
    input  wire logic [tli_pkg::VALUE_W-1:0] i_divisor,
    output logic                            o_done,
    output logic      [tli_pkg::QUO_W-1:0]   o_quotient
);
    import tli_pkg::*;

    localparam logic [QUO_W-1:0] QUO_CAP = QUO_W'(1) << VALUE_W;

    t_div_state           r_state, n_state;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W-1:0]   r_rem, n_rem;
    logic [VALUE_W-1:0]   r_quo, n_quo;
    logic [VALUE_W-1:0]   r_low, n_low;
    logic [VALUE_W-1:0]   r_div, n_div;
    logic [QUO_W-1:0]     r_result, n_result;

    logic [VALUE_W:0]     trial;
    logic [VALUE_W-1:0]   rem_s;
    logic [VALUE_W-1:0]   quo_s;
    logic [VALUE_W-1:0]   low_s;

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_low    = r_low;
        n_div    = r_div;
        n_result = r_result;
        rem_s    = r_rem;
        quo_s    = r_quo;
        low_s    = r_low;
        trial    = '0;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_div = i_divisor;
                    // A high half at or above the divisor means the quotient
                    // cannot fit, so it is capped at once.
                    if (i_dividend[PROD_W-1:VALUE_W] >= i_divisor) begin
                        n_result = QUO_CAP;
                        n_done   = 1'b1;
                    end else begin
                        n_rem   = i_dividend[PROD_W-1:VALUE_W];
                        n_low   = i_dividend[VALUE_W-1:0];
                        n_quo   = '0;
                        n_cnt   = '0;
                        n_state = D_RUN;
                    end
                end
            end
            D_RUN: begin
                for (int s = 0; s < DIV_STEPS; s++) begin
                    trial = {rem_s, low_s[VALUE_W-1]};
                    low_s = {low_s[VALUE_W-2:0], 1'b0};
                    if (trial >= {1'b0, r_div}) begin
                        trial = trial - {1'b0, r_div};
                        quo_s = {quo_s[VALUE_W-2:0], 1'b1};
                    end else begin
                        quo_s = {quo_s[VALUE_W-2:0], 1'b0};
                    end
                    rem_s = trial[VALUE_W-1:0];
                end
                n_rem = rem_s;
                n_quo = quo_s;
                n_low = low_s;
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
                    n_state = D_ROUND;
                end
            end
            D_ROUND: begin
                // Round up when the remainder is at least half the divisor.
                n_result = {1'b0, r_quo} + QUO_W'(r_rem >= (r_div - r_rem));
                n_done   = 1'b1;
                n_state  = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_low    <= n_low;
        r_div    <= n_div;
        r_result <= n_result;
    end

    assign o_done     = r_done;
    assign o_quotient = r_result;

endmodule

`default_nettype wire

/* hdl/table_linear_interpolator.sv */
// Top level of the table linear interpolator: request sequencer, binary
// search, segment checks and result saturation. Uses tli_pkg, tli_table_mem
// and tli_divider.
//
//   channel   handshake                     payload
//   request   start / busy                  i_command, i_entry_index, i_x_value,
//                                           i_y_value, i_query_value
//   result    o_result_valid (one cycle)    o_result_value, o_status,
//                                           o_segment_index
//   config    APB psel/penable/pwrite       paddr, pwdata, prdata (entry_count)
//
// A write request updates the table at the accepting edge; its result shows
// in the next cycle and busy stays low, so writes may follow each other.
// A query holds busy high through the search reads of the x memory, the
// check of the last x, the segment reads and checks, and, when a division is
// needed, the start of the serial divider and the wait for it; its result
// shows in the first cycle with busy low.
// Reset is synchronous and clears the sequencer and entry_count (to 2); the
// table holds nothing defined until written. Results cannot be held off.
`default_nettype none

module table_linear_interpolator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_command,
    input  wire logic        [tli_pkg::ADDR_W-1:0]   i_entry_index,
    input  wire logic signed [tli_pkg::VALUE_W-1:0]  i_x_value,
    input  wire logic signed [tli_pkg::VALUE_W-1:0]  i_y_value,
    input  wire logic signed [tli_pkg::VALUE_W-1:0]  i_query_value,
    output logic                                     o_result_valid,
    output logic signed      [tli_pkg::VALUE_W-1:0]  o_result_value,
    output logic             [tli_pkg::STATUS_W-1:0] o_status,
    output logic             [tli_pkg::ADDR_W-1:0]   o_segment_index,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [tli_pkg::PADDR_W-1:0]  paddr,
    input  wire logic        [tli_pkg::APB_DATA_W-1:0] pwdata,
    output logic             [tli_pkg::APB_DATA_W-1:0] prdata,
    output logic                                     pready
);
    import tli_pkg::*;

    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'((64'sd1 <<< (VALUE_W - 1)) - 1);
    localparam logic signed [RES_W-1:0] RES_MIN = -RES_MAX - RES_W'(1);

    // Control state.
    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_entry_count;

    // Query working registers.
    logic signed [VALUE_W-1:0] r_q, n_q;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [ADDR_W-1:0]  r_mid, n_mid;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic signed [VALUE_W-1:0] r_x0, n_x0;
    logic signed [VALUE_W-1:0] r_y0, n_y0;
    logic signed [DIFF_W-1:0]  r_dq0, n_dq0;
    logic signed [DIFF_W-1:0]  r_dq1, n_dq1;
    logic signed [DIFF_W-1:0]  r_dx, n_dx;
    logic signed [DIFF_W-1:0]  r_dy, n_dy;
    logic [VALUE_W-1:0] r_m0, n_m0;
    logic [VALUE_W-1:0] r_m1, n_m1;
    logic [VALUE_W-1:0] r_mdy, n_mdy;
    logic [VALUE_W-1:0] r_mdx, n_mdx;
    logic               r_outside, n_outside;
    logic               r_neg, n_neg;
    logic [STATUS_W-1:0] r_sts, n_sts;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic signed [VALUE_W-1:0] r_out_value, n_out_value;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [ADDR_W-1:0]  r_out_seg, n_out_seg;

    // Combinational helpers.
    logic [CNT_W-1:0]   count_used;
    logic [CNT_W-1:0]   count_last;
    logic               accept;
    logic               cfg_write;
    logic               le_q;
    logic [CNT_W-1:0]   lo_next;
    logic [CNT_W-1:0]   hi_next;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   idx_sel;
    logic               far;
    logic               last_seg;
    logic [STATUS_W-1:0] seg_sts;
    logic signed [RES_W-1:0] res_sum;

    t_mem_wr            mem_wr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VALUE_W-1:0] rd_x;
    logic [VALUE_W-1:0] rd_y;

    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT)
                       ? APB_DATA_W'(r_entry_count) : '0;

    always_comb begin
        if (r_entry_count < CNT_W'(MIN_COUNT)) begin
            count_used = CNT_W'(MIN_COUNT);
        end else if (r_entry_count > CNT_W'(TABLE_DEPTH)) begin
            count_used = CNT_W'(TABLE_DEPTH);
        end else begin
            count_used = r_entry_count;
        end
    end

    assign count_last = r_n - CNT_W'(1);

    assign mem_wr.en   = accept && (i_command == CMD_WRITE);
    assign mem_wr.addr = i_entry_index;
    assign mem_wr.x    = i_x_value;
    assign mem_wr.y    = i_y_value;

    tli_table_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    tli_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_mdx),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state      = r_state;
        n_out_valid  = 1'b0;
        n_q          = r_q;
        n_n          = r_n;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_idx        = r_idx;
        n_x0         = r_x0;
        n_y0         = r_y0;
        n_dq0        = r_dq0;
        n_dq1        = r_dq1;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_m0         = r_m0;
        n_m1         = r_m1;
        n_mdy        = r_mdy;
        n_mdx        = r_mdx;
        n_outside    = r_outside;
        n_neg        = r_neg;
        n_sts        = r_sts;
        n_prod       = r_prod;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_seg    = r_out_seg;
        rd_addr      = r_mid;
        div_start    = 1'b0;

        le_q     = ($signed(rd_x) <= r_q);
        lo_next  = le_q ? ({1'b0, r_mid} + CNT_W'(1)) : r_lo;
        hi_next  = le_q ? r_hi : {1'b0, r_mid};
        mid_sum  = {1'b0, lo_next} + {1'b0, hi_next};
        idx_sel  = (r_q >= $signed(rd_x)) ? count_last : r_lo;
        far      = ({{(RATIO_W-VALUE_W){1'b0}}, r_m0} >
                    ({{(RATIO_W-VALUE_W){1'b0}}, r_m1} * RATIO_W'(RATIO_LIMIT)))
                || (({{(RATIO_W-VALUE_W){1'b0}}, r_m0} * RATIO_W'(RATIO_LIMIT)) <
                    {{(RATIO_W-VALUE_W){1'b0}}, r_m1});
        last_seg = (({1'b0, r_idx} + CNT_W'(1)) == r_n);
        seg_sts  = r_outside ? ST_EXTRAP : ST_OK;
        res_sum  = r_neg ? (RES_W'(r_y0) - $signed({1'b0, div_quo}))
                         : (RES_W'(r_y0) + $signed({1'b0, div_quo}));

        case (r_state)
            S_IDLE: begin
                rd_addr = count_used[CNT_W-1:1];
                if (accept) begin
                    if (i_command == CMD_WRITE) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = '0;
                        n_out_status = ST_WRITE;
                        n_out_seg    = '0;
                    end else begin
                        n_q     = i_query_value;
                        n_n     = count_used;
                        n_lo    = '0;
                        n_hi    = count_used;
                        n_mid   = count_used[CNT_W-1:1];
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // The read of x at mid issued last cycle is compared here and
                // the next probe is addressed in the same cycle.
                n_lo = lo_next;
                n_hi = hi_next;
                if (lo_next < hi_next) begin
                    n_mid   = mid_sum[ADDR_W:1];
                    rd_addr = mid_sum[ADDR_W:1];
                end else begin
                    rd_addr = count_last[ADDR_W-1:0];
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // A value at or past the last x is put onto the last segment.
                if (idx_sel == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = ST_RANGE;
                    n_out_seg    = '0;
                    n_state      = S_IDLE;
                end else begin
                    n_idx   = idx_sel[ADDR_W-1:0];
                    rd_addr = idx_sel[ADDR_W-1:0] - ADDR_W'(1);
                    n_state = S_LOWER;
                end
            end
            S_LOWER: begin
                n_x0    = $signed(rd_x);
                n_y0    = $signed(rd_y);
                rd_addr = r_idx;
                n_state = S_UPPER;
            end
            S_UPPER: begin
                n_dq0   = DIFF_W'(r_q) - DIFF_W'(r_x0);
                n_dq1   = DIFF_W'(r_q) - DIFF_W'($signed(rd_x));
                n_dx    = DIFF_W'($signed(rd_x)) - DIFF_W'(r_x0);
                n_dy    = DIFF_W'($signed(rd_y)) - DIFF_W'(r_y0);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_m0      = diff_mag(r_dq0);
                n_m1      = diff_mag(r_dq1);
                n_mdy     = diff_mag(r_dy);
                n_mdx     = diff_mag(r_dx);
                n_outside = ((r_dq0 > 0) && (r_dq1 > 0)) || ((r_dq0 < 0) && (r_dq1 < 0));
                n_neg     = r_dy[DIFF_W-1] ^ r_dq0[DIFF_W-1] ^ r_dx[DIFF_W-1];
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                n_prod = PROD_W'(r_mdy) * PROD_W'(r_m0);
                n_sts  = seg_sts;
                if (r_outside && !(last_seg && far)) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = ST_DOMAIN;
                    n_out_seg    = r_idx;
                    n_state      = S_IDLE;
                end else if (r_mdx == '0) begin
                    // Equal breakpoints give the lower y directly.
                    n_out_valid  = 1'b1;
                    n_out_value  = r_y0;
                    n_out_status = seg_sts;
                    n_out_seg    = r_idx;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_sts;
                    n_out_seg    = r_idx;
                    if (res_sum > RES_MAX) begin
                        n_out_value = RES_MAX[VALUE_W-1:0];
                    end else if (res_sum < RES_MIN) begin
                        n_out_value = RES_MIN[VALUE_W-1:0];
                    end else begin
                        n_out_value = res_sum[VALUE_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= ENTRY_COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_write && (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT)) begin
                r_entry_count <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q          <= n_q;
        r_n          <= n_n;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_idx        <= n_idx;
        r_x0         <= n_x0;
        r_y0         <= n_y0;
        r_dq0        <= n_dq0;
        r_dq1        <= n_dq1;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_m0         <= n_m0;
        r_m1         <= n_m1;
        r_mdy        <= n_mdy;
        r_mdx        <= n_mdx;
        r_outside    <= n_outside;
        r_neg        <= n_neg;
        r_sts        <= n_sts;
        r_prod       <= n_prod;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_seg    <= n_out_seg;
    end

    assign o_result_valid  = r_out_valid;
    assign o_result_value  = r_out_value;
    assign o_status        = r_out_status;
    assign o_segment_index = r_out_seg;

`ifndef ASSERT_OFF
    // A write result appears in the cycle after its write request is accepted.
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_WRITE))
        |-> $past(start && !busy && (i_command == CMD_WRITE)))
        else $error("write result without a write request one cycle earlier");

    // A query result appears only as the sequencer has just finished.
    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status != ST_WRITE)) |-> (!busy && $past(busy)))
        else $error("query result outside the end of a query");

    // Writes and out-of-range queries carry zero value and segment.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && ((o_status == ST_WRITE) || (o_status == ST_RANGE)))
        |-> ((o_result_value == '0) && (o_segment_index == '0)))
        else $error("nonzero payload on a write or out-of-range result");

    // The divider only reports back while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished while no division was pending");
`endif

endmodule

`default_nettype wire

/* sim/table_linear_interpolator_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for table_linear_interpolator: directed requests, then random table
// loads and queries; results are checked against given values or in-bench interpolation.
// Depends on tli_pkg and the table_linear_interpolator RTL.

module table_linear_interpolator_test;

    import tli_pkg::*;

    localparam int     CYCLE_LIMIT       = 200000;
    localparam int     PHASES            = 12;
    localparam int     QUERIES_PER_PHASE = 26;
    localparam int     PLAN_ROWS         = 24;
    localparam longint VALUE_MAX         = (longint'(1) << (VALUE_W - 1)) - 1;
    localparam longint VALUE_MIN         = -VALUE_MAX - 1;
    localparam logic [63:0] QUOTIENT_CAP = 64'd1 << VALUE_W;
    localparam logic [PADDR_W-1:0] COUNT_ADDR = PADDR_W'(4 * REG_ENTRY_COUNT);

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value;
        logic        [STATUS_W-1:0] status;
        logic        [ADDR_W-1:0]   segment;
    } t_lookup;

    typedef struct packed {
        logic                      cmd;
        logic [ADDR_W-1:0]         slot;
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] y;
        logic signed [VALUE_W-1:0] q;
        logic                      known;
        t_lookup                   outcome;
    } t_plan_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_command;
    logic [ADDR_W-1:0]          i_entry_index;
    logic signed [VALUE_W-1:0]  i_x_value;
    logic signed [VALUE_W-1:0]  i_y_value;
    logic signed [VALUE_W-1:0]  i_query_value;
    logic                       o_result_valid;
    logic signed [VALUE_W-1:0]  o_result_value;
    logic [STATUS_W-1:0]        o_status;
    logic [ADDR_W-1:0]          o_segment_index;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    // Bench copy of the breakpoint table and of the entry_count register.
    logic signed [VALUE_W-1:0]  tbl_x [TABLE_DEPTH];
    logic signed [VALUE_W-1:0]  tbl_y [TABLE_DEPTH];
    logic [CNT_W-1:0]           count_reg;
    bit                         full_table_built;

    t_lookup                    awaited_results [$];
    int                         mismatches = 0;
    int                         cycles = 0;
    bit                         sender_gaps = 1'b1;
    t_plan_row                  demo_plan [PLAN_ROWS];
    int unsigned                phase_counts [PHASES] =
        '{2, 7, 0, 256, 12, 1, 4, 511, 20, 257, 3, 9};

    table_linear_interpolator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_entry_index   (i_entry_index),
        .i_x_value       (i_x_value),
        .i_y_value       (i_y_value),
        .i_query_value   (i_query_value),
        .o_result_valid  (o_result_valid),
        .o_result_value  (o_result_value),
        .o_status        (o_status),
        .o_segment_index (o_segment_index),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("run stopped at the cycle limit with %0d results outstanding",
                     awaited_results.size());
            $display("FAIL table_linear_interpolator");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Results are taken at the edge that ends their single valid cycle.
    always @(posedge i_clk) begin : check_results
        t_lookup want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
                note_mismatch("unrequested result", 64'(o_status), 64'(o_result_value));
            end else begin
                want = awaited_results.pop_front();
                if (o_result_value !== want.value)
                    note_mismatch("result_value", 64'(o_result_value), 64'(want.value));
                if (o_status !== want.status)
                    note_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_segment_index !== want.segment)
                    note_mismatch("segment_index", 64'(o_segment_index), 64'(want.segment));
            end
        end
    end

    function automatic int entries_in_use();
        if (count_reg < MIN_COUNT)
            return MIN_COUNT;
        if (count_reg > TABLE_DEPTH)
            return TABLE_DEPTH;
        return int'(count_reg);
    endfunction

    // Interpolated y at q from the bench table, exact and rounded half away from zero.
    function automatic t_lookup lookup_point(input logic signed [VALUE_W-1:0] q);
        t_lookup     r;
        int          n, lo, hi, mid, seg;
        longint      x0, x1, y0, y1, dq0, dq1, dx, dy, acc;
        logic [63:0] m0, m1, mdx, mdy, prod, quo, rem;
        r = '{value: '0, status: ST_OK, segment: '0};
        n = entries_in_use();
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_x[mid] <= q)
                lo = mid + 1;
            else
                hi = mid;
        end
        seg = lo;
        if (q >= tbl_x[n-1])
            seg = n - 1;
        if (seg == 0) begin
            r.status = ST_RANGE;
            return r;
        end
        x0 = longint'(tbl_x[seg-1]);
        x1 = longint'(tbl_x[seg]);
        y0 = longint'(tbl_y[seg-1]);
        y1 = longint'(tbl_y[seg]);
        dq0 = longint'(q) - x0;
        dq1 = longint'(q) - x1;
        r.segment = ADDR_W'(seg);
        if ((dq0 > 0 && dq1 > 0) || (dq0 < 0 && dq1 < 0)) begin
            m0 = (dq0 < 0) ? -dq0 : dq0;
            m1 = (dq1 < 0) ? -dq1 : dq1;
            // Only the last segment extrapolates, and only when the query is well clear.
            if (seg + 1 == n && (m0 > m1 * RATIO_LIMIT || m0 * RATIO_LIMIT < m1)) begin
                r.status = ST_EXTRAP;
            end else begin
                r.status = ST_DOMAIN;
                return r;
            end
        end
        dx = x1 - x0;
        dy = y1 - y0;
        if (dx == 0 || dy == 0 || dq0 == 0) begin
            acc = y0;
        end else begin
            mdx = (dx < 0) ? -dx : dx;
            mdy = (dy < 0) ? -dy : dy;
            m0 = (dq0 < 0) ? -dq0 : dq0;
            prod = mdy * m0;
            quo = prod / mdx;
            rem = prod % mdx;
            if (quo >= QUOTIENT_CAP)
                quo = QUOTIENT_CAP;
            else if (rem >= mdx - rem)
                quo = quo + 1;
            if (quo > QUOTIENT_CAP)
                quo = QUOTIENT_CAP;
            acc = ((dy < 0) ^ (dq0 < 0) ^ (dx < 0)) ? y0 - longint'(quo) : y0 + longint'(quo);
        end
        if (acc > VALUE_MAX)
            acc = VALUE_MAX;
        if (acc < VALUE_MIN)
            acc = VALUE_MIN;
        r.value = acc[VALUE_W-1:0];
        return r;
    endfunction

    function automatic t_plan_row write_row(input logic [ADDR_W-1:0] slot,
                                            input logic signed [VALUE_W-1:0] x, y);
        return '{cmd: CMD_WRITE, slot: slot, x: x, y: y, q: '0, known: 1'b1,
                 outcome: '{value: '0, status: ST_WRITE, segment: '0}};
    endfunction

    function automatic t_plan_row query_row(input logic signed [VALUE_W-1:0] q);
        return '{cmd: CMD_QUERY, slot: '0, x: '0, y: '0, q: q, known: 1'b0, outcome: '0};
    endfunction

    function automatic t_plan_row known_query(input logic signed [VALUE_W-1:0] q, value,
                                              input logic [STATUS_W-1:0] status,
                                              input logic [ADDR_W-1:0] segment);
        return '{cmd: CMD_QUERY, slot: '0, x: '0, y: '0, q: q, known: 1'b1,
                 outcome: '{value: value, status: status, segment: segment}};
    endfunction

    // Presents one request, waits for it to be taken and records what it should return.
    task automatic run_request(input logic cmd, input logic [ADDR_W-1:0] slot,
                               input logic signed [VALUE_W-1:0] x, y, q,
                               input logic known, input t_lookup given);
        t_lookup want;
        i_command     <= cmd;
        i_entry_index <= slot;
        i_x_value     <= x;
        i_y_value     <= y;
        i_query_value <= q;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        if (cmd == CMD_WRITE) begin
            tbl_x[slot] = x;
            tbl_y[slot] = y;
            want = '{value: '0, status: ST_WRITE, segment: '0};
        end else begin
            want = lookup_point(q);
        end
        if (known)
            want = given;
        awaited_results = {awaited_results, want};
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic settle(input int margin);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (margin) @(posedge i_clk);
    endtask

    // Optionally writes entry_count, then reads it back over a second transfer.
    task automatic access_count(input logic update, input logic [CNT_W-1:0] value);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        paddr   <= COUNT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        pwrite  <= update;
        if (update) begin
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            count_reg = value;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DATA_W'(value))
            note_mismatch("entry_count read-back", 64'(got), 64'(value));
    endtask

    initial begin
        int     n, k, pick;
        longint step_cap, room, xpos, qv, span;
        bit     shuffled;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= CMD_WRITE;
        i_entry_index <= '0;
        i_x_value     <= '0;
        i_y_value     <= '0;
        i_query_value <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        count_reg      = ENTRY_COUNT_RESET;
        full_table_built = 1'b0;

        demo_plan = '{
            write_row(ADDR_W'(0), 32'h0000_0000, 32'h0000_0000),
            write_row(ADDR_W'(1), 32'h0001_0000, 32'h0002_0000),
            known_query(32'h0000_8000, 32'h0001_0000, ST_OK, ADDR_W'(1)),
            known_query(32'h0000_0000, 32'h0000_0000, ST_OK, ADDR_W'(1)),
            known_query(32'h0001_0000, 32'h0002_0000, ST_OK, ADDR_W'(1)),
            known_query(32'hFFFF_FFFF, 32'h0000_0000, ST_RANGE, ADDR_W'(0)),
            known_query(32'h8000_0000, 32'h0000_0000, ST_RANGE, ADDR_W'(0)),
            known_query(32'h7FFF_FFFF, 32'h0000_0000, ST_DOMAIN, ADDR_W'(1)),
            query_row(32'h0001_0CCD),
            write_row(ADDR_W'(255), 32'h7FFF_FFFF, 32'h8000_0000),
            // Steep last segment: a query just past it extrapolates into saturation.
            write_row(ADDR_W'(1), 32'd100, 32'h7FFF_FFFF),
            known_query(32'd105, 32'h7FFF_FFFF, ST_EXTRAP, ADDR_W'(1)),
            write_row(ADDR_W'(1), 32'd100, 32'h8000_0000),
            known_query(32'd105, 32'h8000_0000, ST_EXTRAP, ADDR_W'(1)),
            // A ratio of exactly ten is not far enough to extrapolate.
            write_row(ADDR_W'(1), 32'h0009_0000, 32'h0001_0000),
            known_query(32'h000A_0000, 32'h0000_0000, ST_DOMAIN, ADDR_W'(1)),
            query_row(32'h0009_FFFF),
            write_row(ADDR_W'(0), 32'h0005_0000, 32'h0003_0000),
            write_row(ADDR_W'(1), 32'h0005_0000, 32'h0007_0000),
            known_query(32'h0005_0000, 32'h0003_0000, ST_OK, ADDR_W'(1)),
            // Descending breakpoints: the search still runs, with a ratio below a tenth.
            write_row(ADDR_W'(0), 32'h000A_0000, 32'h0001_0000),
            query_row(32'h000A_4000),
            query_row(32'h0007_0000),
            known_query(32'hFFFF_0000, 32'h0000_0000, ST_RANGE, ADDR_W'(0))
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        access_count(1'b0, ENTRY_COUNT_RESET);

        foreach (demo_plan[r])
            run_request(demo_plan[r].cmd, demo_plan[r].slot, demo_plan[r].x, demo_plan[r].y,
                        demo_plan[r].q, demo_plan[r].known, demo_plan[r].outcome);

        for (int p = 0; p < PHASES; p++) begin
            settle(4);
            access_count(1'b1, CNT_W'(phase_counts[p]));
            n = entries_in_use();
            sender_gaps = (p < PHASES - 2);
            shuffled = ($urandom_range(0, 4) == 0);

            // Load every entry the search can touch; a full table is loaded only once.
            if (n < TABLE_DEPTH || !full_table_built) begin
                step_cap = ((longint'(1) << VALUE_W) / n - 1) >> $urandom_range(0, 24);
                if (step_cap < 1)
                    step_cap = 1;
                room = (longint'(1) << VALUE_W) - 1 - longint'(n) * step_cap;
                xpos = VALUE_MIN + longint'({$urandom, $urandom} >> 1) % (room + 1);
                for (int s = 0; s < n; s++) begin
                    run_request(CMD_WRITE, ADDR_W'(s),
                                shuffled ? VALUE_W'($urandom) : VALUE_W'(xpos),
                                VALUE_W'($urandom), VALUE_W'($urandom), 1'b0, '0);
                    xpos += ($urandom_range(0, 7) == 0) ? 0 :
                            1 + longint'({$urandom, $urandom} >> 1) % step_cap;
                end
                if (n == TABLE_DEPTH)
                    full_table_built = 1'b1;
            end

            for (int i = 0; i < QUERIES_PER_PHASE; i++) begin
                pick = $urandom_range(0, 19);
                k = $urandom_range(1, n - 1);
                if (pick < 2) begin
                    run_request(CMD_WRITE, ADDR_W'($urandom), VALUE_W'($urandom),
                                VALUE_W'($urandom), VALUE_W'($urandom), 1'b0, '0);
                    continue;
                end
                if (pick < 10) begin
                    qv = longint'(tbl_x[k-1]) + (longint'(tbl_x[k]) - longint'(tbl_x[k-1]))
                         * longint'($urandom_range(0, 1024)) / 1024;
                end else if (pick < 12) begin
                    qv = longint'(tbl_x[$urandom_range(0, n - 1)]);
                end else if (pick < 15) begin
                    span = longint'(tbl_x[n-1]) - longint'(tbl_x[n-2]);
                    if (span < 0)
                        span = -span;
                    qv = longint'(tbl_x[n-1]) + longint'($urandom) % (span / 4 + 2);
                end else if (pick < 17) begin
                    qv = longint'(tbl_x[0]) - 1 - (longint'($urandom) >> $urandom_range(0, 31));
                end else begin
                    qv = longint'(int'($urandom));
                end
                if (qv > VALUE_MAX)
                    qv = VALUE_MAX;
                if (qv < VALUE_MIN)
                    qv = VALUE_MIN;
                run_request(CMD_QUERY, ADDR_W'($urandom), VALUE_W'($urandom),
                            VALUE_W'($urandom), VALUE_W'(qv), 1'b0, '0);
            end
        end

        settle(40);
        if (mismatches == 0)
            $display("PASS table_linear_interpolator");
        else
            $display("FAIL table_linear_interpolator");
        $finish;
    end

endmodule
